// File: design/afrf_pkg.sv
// ----------------------------------------------------------------------------
// afrf_pkg: shared types and constants of the ARM64 function reference finder
// Instruction encodings, the decoded word carried from front to back, and
// configuration register indexes.
// ----------------------------------------------------------------------------
package afrf_pkg;

   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned IMM12_W = 12;
   localparam int unsigned CSR_IDX_W = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ADDRESS = 1'b1;

   // instruction encodings
   localparam logic [WORD_W-1:0] RET_WORD       = 32'hD65F03C0;
   localparam logic [WORD_W-1:0] ADRP_MASK      = 32'h9F000000;
   localparam logic [WORD_W-1:0] ADRP_MATCH     = 32'h90000000;
   localparam logic [WORD_W-1:0] ADD_MASK       = 32'hFFC00000;
   localparam logic [WORD_W-1:0] ADD_MATCH      = 32'h91000000;
   localparam logic [WORD_W-1:0] STP_FP_MASK    = 32'hFFC07FFF;
   localparam logic [WORD_W-1:0] STP_FP_MATCH   = 32'hA9807BFD;
   localparam logic [WORD_W-1:0] SUB_SP_MASK    = 32'hFFC003FF;
   localparam logic [WORD_W-1:0] SUB_SP_MATCH   = 32'hD10003FF;

   // one classified instruction word
   typedef struct packed {
      logic                 is_ret;
      logic                 is_adrp;
      logic                 is_prologue;
      logic                 is_add;
      logic [REG_W-1:0]     add_rd;
      logic [REG_W-1:0]     add_rn;
      logic [REG_W-1:0]     adrp_rd;
      logic [IMM12_W-1:0]   imm12;
      logic [ADDR_W-1:0]    adrp_page;
      logic [ADDR_W-1:0]    word_addr;
      logic                 last_word;
   } afrf_entry_type;

endpackage

// File: design/afrf_front.sv
// ----------------------------------------------------------------------------
// afrf_front: word intake and classification
// Tracks the address of each word, decodes the patterns of interest and
// precomputes the ADRP page value for the back end.
// ----------------------------------------------------------------------------
module afrf_front
   import afrf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [WORD_W-1:0]     req_instr_word,
   input  logic                  req_last_word,
   input  logic                  queue_full,
   input  logic                  base_write,
   input  logic [ADDR_W-1:0]     base_data,
   output logic                  push,
   output afrf_entry_type        push_entry
);

   logic [ADDR_W-1:0] base_address_ff, base_address_in;
   logic [ADDR_W-1:0] word_address_ff, word_address_in;
   logic [20:0]       imm21;
   logic [ADDR_W-1:0] adrp_offset;

   assign push = req_valid && !queue_full;

   // ADRP immediate: immhi:immlo, sign-extended and scaled by 4 KiB pages
   assign imm21       = {req_instr_word[23:5], req_instr_word[30:29]};
   assign adrp_offset = {{31{imm21[20]}}, imm21, 12'h000};

   always_comb begin
      push_entry.is_ret      = (req_instr_word == RET_WORD);
      push_entry.is_adrp     = ((req_instr_word & ADRP_MASK) == ADRP_MATCH);
      push_entry.is_prologue = ((req_instr_word & STP_FP_MASK) == STP_FP_MATCH) ||
                               ((req_instr_word & SUB_SP_MASK) == SUB_SP_MATCH);
      push_entry.is_add      = ((req_instr_word & ADD_MASK) == ADD_MATCH);
      push_entry.add_rd      = req_instr_word[4:0];
      push_entry.add_rn      = req_instr_word[9:5];
      push_entry.adrp_rd     = req_instr_word[4:0];
      push_entry.imm12       = req_instr_word[21:10];
      push_entry.adrp_page   = {word_address_ff[ADDR_W-1:12], 12'h000} + adrp_offset;
      push_entry.word_addr   = word_address_ff;
      push_entry.last_word   = req_last_word;
   end

   always_comb begin
      base_address_in = base_address_ff;
      word_address_in = word_address_ff;
      if (base_write) begin
         base_address_in = base_data;
         word_address_in = base_data;
      end else if (push) begin
         word_address_in = req_last_word ? base_address_ff : word_address_ff + 64'd4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
         word_address_ff <= '0;
      end else begin
         base_address_ff <= base_address_in;
         word_address_ff <= word_address_in;
      end
   end

endmodule

// File: design/afrf_queue.sv
// ----------------------------------------------------------------------------
// afrf_queue: short FIFO of classified words
// Decouples the front end from the back end so either side can stall.
// ----------------------------------------------------------------------------
module afrf_queue
   import afrf_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  afrf_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           head_valid,
   output afrf_entry_type head_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   afrf_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/afrf_back.sv
// ----------------------------------------------------------------------------
// afrf_back: search state machine and result register
// Applies one classified word per cycle, whenever the result register is free or
// draining, to the search mode, pairs ADRP/ADD, checks the target and issues the section answer.
// ----------------------------------------------------------------------------
module afrf_back
   import afrf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  afrf_entry_type      head_entry,
   output logic                pop,
   input  logic                target_write,
   input  logic [ADDR_W-1:0]   target_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [ADDR_W-1:0]   rsp_function_address
);

   typedef enum logic [1:0] {
      MODE_SCAN,
      MODE_IN_FN,
      MODE_FOUND
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [ADDR_W-1:0]   function_start_ff, function_start_in;
   logic                adrp_pending_ff, adrp_pending_in;
   logic                answered_ff, answered_in;
   logic [ADDR_W-1:0]   held_page_ff, held_page_in;
   logic [REG_W-1:0]    held_rd_ff, held_rd_in;
   logic [ADDR_W-1:0]   target_address_ff, target_address_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [ADDR_W-1:0]   rsp_function_address_ff, rsp_function_address_in;

   logic                emit;
   logic                emit_found;
   logic                consumed;
   logic [ADDR_W-1:0]   resolved;

   // advance whenever the result register is free or being drained
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   assign resolved = held_page_ff + {{(ADDR_W-IMM12_W){1'b0}}, head_entry.imm12};

   always_comb begin
      mode_in           = mode_ff;
      function_start_in = function_start_ff;
      adrp_pending_in   = adrp_pending_ff;
      answered_in       = answered_ff;
      held_page_in      = held_page_ff;
      held_rd_in        = held_rd_ff;
      target_address_in = target_write ? target_data : target_address_ff;
      emit              = 1'b0;
      emit_found        = 1'b0;
      consumed          = 1'b0;

      if (pop) begin
         if (!answered_ff) begin
            if (adrp_pending_ff) begin
               adrp_pending_in = 1'b0;
               if (head_entry.is_add && head_entry.add_rd == held_rd_ff &&
                   head_entry.add_rn == held_rd_ff) begin
                  if (target_address_ff != '0 && resolved == target_address_ff) begin
                     mode_in = MODE_FOUND;
                  end
                  consumed = 1'b1;
               end
            end
            if (!consumed) begin
               if (head_entry.is_ret) begin
                  if (mode_ff == MODE_FOUND) begin
                     emit        = 1'b1;
                     emit_found  = 1'b1;
                     answered_in = 1'b1;
                  end else begin
                     mode_in = MODE_SCAN;
                  end
               end else if (head_entry.is_adrp) begin
                  if (mode_ff == MODE_IN_FN && !head_entry.last_word) begin
                     held_page_in    = head_entry.adrp_page;
                     held_rd_in      = head_entry.adrp_rd;
                     adrp_pending_in = 1'b1;
                  end
               end else if (head_entry.is_prologue) begin
                  if (mode_ff == MODE_SCAN) begin
                     function_start_in = head_entry.word_addr;
                     mode_in           = MODE_IN_FN;
                  end
               end
            end
         end
         if (head_entry.last_word) begin
            // section closes: report a miss unless already answered, then restart
            if (!answered_ff && !emit) begin
               emit = 1'b1;
            end
            mode_in           = MODE_SCAN;
            function_start_in = '0;
            adrp_pending_in   = 1'b0;
            answered_in       = 1'b0;
         end
      end

      rsp_found_in            = rsp_found_ff;
      rsp_function_address_in = rsp_function_address_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_found_in            = emit_found;
         rsp_function_address_in = emit_found ? function_start_ff : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_SCAN;
         function_start_ff <= '0;
         adrp_pending_ff   <= 1'b0;
         answered_ff       <= 1'b0;
         target_address_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         mode_ff           <= mode_in;
         function_start_ff <= function_start_in;
         adrp_pending_ff   <= adrp_pending_in;
         answered_ff       <= answered_in;
         target_address_ff <= target_address_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      held_page_ff            <= held_page_in;
      held_rd_ff              <= held_rd_in;
      rsp_found_ff            <= rsp_found_in;
      rsp_function_address_ff <= rsp_function_address_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_function_address = rsp_function_address_ff;

endmodule

// File: design/arm64_function_reference_finder_top.sv
// Path: the word that causes a result beat is held in a queue slot, then the beat
//   is registered in the result register.
// Throughput: one instruction word per cycle while the queue has a free slot; the back end retires one queued
//   word each cycle that the result register is free or being drained.
// Reset (synchronous, active high) clears the search state, the queue and both
//   configuration registers.
// ----------------------------------------------------------------------------
// arm64_function_reference_finder_top: ARM64 ADRP/ADD reference search
// Streams the instruction words of a section, tracks prologue, function body
// and found modes, and reports the start of the first function that forms
// the target address, or a miss at the end of the section.
// ----------------------------------------------------------------------------
module arm64_function_reference_finder_top
   import afrf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic                  clock,
   input  logic                  reset,
   // instruction word channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [WORD_W-1:0]     req_instr_word,
   input  logic                  req_last_word,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [ADDR_W-1:0]     rsp_function_address,
   // configuration writes
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]     csr_write_data
);

   logic           base_write;
   logic           target_write;
   logic           push;
   afrf_entry_type push_entry;
   logic           queue_full;
   logic           head_valid;
   afrf_entry_type head_entry;
   logic           pop;

   // Decode the register index; the base address goes to the front end,
   // which also reloads its running word address, and the target to the back.
   assign base_write   = csr_write_enable && (csr_index == CSR_BASE_ADDRESS);
   assign target_write = csr_write_enable && (csr_index == CSR_TARGET_ADDRESS);

   // Stall new beats only when the queue has no free slot.
   assign req_stall = queue_full;

   // Front end: address tracking and pattern decode.
   afrf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_instr_word (req_instr_word),
      .req_last_word  (req_last_word),
      .queue_full     (queue_full),
      .base_write     (base_write),
      .base_data      (csr_write_data),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Hold classified words between the two halves.
   afrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back end: mode tracking, ADRP/ADD resolution and the result register.
   afrf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_entry           (head_entry),
      .pop                  (pop),
      .target_write         (target_write),
      .target_data          (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_function_address (rsp_function_address)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for arm64_function_reference_finder_top
// Streams instruction-word sections through the block, first a directed
// table and then sections built from prologues, ADRP/ADD pairs and RETs with
// random content and random noise. An in-bench tracker of the search state
// predicts the result beats, or a directed row types one in, and every beat that
// leaves the block is compared with the oldest expected beat.
// ----------------------------------------------------------------------------
module tb;
   import afrf_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned PHASE_WORDS  = 65;
   localparam int unsigned SETTLE_TICKS = 8;

   typedef enum logic [1:0] {
      SEEK_PROLOGUE,
      IN_BODY,
      REF_FOUND
   } search_mode_type;

   typedef enum logic {
      ROW_BEAT,
      ROW_REG
   } row_kind_type;

   // how a directed row is checked: by the tracker, or by a value typed in
   typedef enum logic [1:0] {
      ANS_PREDICTED,
      ANS_NONE,
      ANS_MISS,
      ANS_HIT
   } answer_check_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] function_address;
   } finder_answer_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [ADDR_W-1:0]    value;     // instruction word in the low bits, or register data
      logic                 last;
      answer_check_type     check;
      logic [ADDR_W-1:0]    hit_addr;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // clock, reset and the block's inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [WORD_W-1:0]    req_instr_word = '0;
   logic                 req_last_word = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_found;
   logic [ADDR_W-1:0]    rsp_function_address;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_write_data = '0;

   arm64_function_reference_finder_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_instr_word       (req_instr_word),
      .req_last_word        (req_last_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_function_address (rsp_function_address),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // search-state tracker: a copy of the block's configuration and state
   // ------------------------------------------------------------------------
   logic [ADDR_W-1:0] cfg_base = '0;
   logic [ADDR_W-1:0] cfg_target = '0;
   search_mode_type   trk_mode = SEEK_PROLOGUE;
   logic [ADDR_W-1:0] trk_fn_start = '0;
   logic [ADDR_W-1:0] trk_pc = '0;
   logic [WORD_W-1:0] trk_adrp_word = '0;
   logic              trk_adrp_pending = 1'b0;
   logic              trk_answered = 1'b0;

   finder_answer_type pending_answers[$];
   int unsigned       mismatches = 0;
   int unsigned       words_sent = 0;
   int unsigned       cycle_count = 0;
   bit                calm_phase = 1'b0;

   function automatic void restart_section();
      trk_mode         = SEEK_PROLOGUE;
      trk_fn_start     = '0;
      trk_pc           = cfg_base;
      trk_adrp_pending = 1'b0;
      trk_answered     = 1'b0;
   endfunction

   // Advance the tracked search by one word; report the result beat it causes.
   function automatic void track_word(input logic [WORD_W-1:0] w, input logic last,
                                      output logic produced, output finder_answer_type ans);
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] adrp_pc;
      logic [ADDR_W-1:0] page_off;
      logic [ADDR_W-1:0] resolved;
      logic [20:0]       imm21;
      logic [REG_W-1:0]  rd;
      logic              consumed;
      pc       = trk_pc;
      trk_pc   = pc + 64'd4;
      produced = 1'b0;
      consumed = 1'b0;
      ans      = '0;
      if (!trk_answered) begin
         if (trk_adrp_pending) begin
            rd = trk_adrp_word[4:0];
            trk_adrp_pending = 1'b0;
            if ((w & ADD_MASK) == ADD_MATCH && w[4:0] == rd && w[9:5] == rd) begin
               // page of the ADRP word plus its signed page offset, then imm12 unshifted
               imm21    = {trk_adrp_word[23:5], trk_adrp_word[30:29]};
               page_off = {{31{imm21[20]}}, imm21, 12'h000};
               adrp_pc  = pc - 64'd4;
               resolved = {adrp_pc[63:12], 12'h000} + page_off + {52'h0, w[21:10]};
               if (cfg_target != '0 && resolved == cfg_target)
                  trk_mode = REF_FOUND;
               consumed = 1'b1;
            end
         end
         if (!consumed) begin
            if (w == RET_WORD) begin
               if (trk_mode == REF_FOUND) begin
                  produced = 1'b1;
                  ans      = '{found: 1'b1, function_address: trk_fn_start};
                  trk_answered = 1'b1;
               end else begin
                  trk_mode = SEEK_PROLOGUE;
               end
            end else if ((w & ADRP_MASK) == ADRP_MATCH) begin
               // an ADRP on the last word can never pair
               if (trk_mode == IN_BODY && !last) begin
                  trk_adrp_word    = w;
                  trk_adrp_pending = 1'b1;
               end
            end else if ((w & STP_FP_MASK) == STP_FP_MATCH ||
                         (w & SUB_SP_MASK) == SUB_SP_MATCH) begin
               if (trk_mode == SEEK_PROLOGUE) begin
                  trk_fn_start = pc;
                  trk_mode     = IN_BODY;
               end
            end
         end
      end
      if (last) begin
         // section end reports a miss unless this word or an earlier one answered
         if (!trk_answered && !produced) begin
            produced = 1'b1;
            ans      = '{found: 1'b0, function_address: '0};
         end
         restart_section();
      end
   endfunction

   // ------------------------------------------------------------------------
   // idle lengths: mostly none, often short, now and then long
   // ------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // Offer one word, hold it until accepted, then record what it should cause.
   // Valid is only lowered here before a gap, so a back-to-back word keeps it high.
   task automatic put_word(input logic [WORD_W-1:0] w, input logic last = 1'b0,
                           input answer_check_type chk = ANS_PREDICTED,
                           input logic [ADDR_W-1:0] hit_addr = '0);
      int unsigned       gap;
      logic              produced;
      finder_answer_type ans;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_instr_word <= w;
      req_last_word  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      track_word(w, last, produced, ans);
      case (chk)
         ANS_PREDICTED: if (produced) pending_answers.push_back(ans);
         ANS_MISS:      pending_answers.push_back('{found: 1'b0, function_address: '0});
         ANS_HIT:       pending_answers.push_back('{found: 1'b1, function_address: hit_addr});
         default: ;
      endcase
   endtask

   // Drop valid, wait out every expected beat, then let in-flight words retire.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      if (idx == CSR_BASE_ADDRESS) begin
         cfg_base = data;
         trk_pc   = data;
      end else begin
         cfg_target = data;
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // ADRP at the current address followed by ADD forming aim; spoil breaks the pair.
   task automatic emit_pair(input logic [ADDR_W-1:0] aim, input bit spoil);
      logic [ADDR_W-1:0] page_gap;
      logic [20:0]       imm21;
      logic [REG_W-1:0]  rd;
      logic [REG_W-1:0]  rn;
      logic [WORD_W-1:0] add_word;
      rd       = REG_W'($urandom_range(0, 31));
      rn       = rd;
      page_gap = {aim[63:12], 12'h000} - {trk_pc[63:12], 12'h000};
      imm21    = page_gap[32:12];
      put_word(ADRP_MATCH | {1'b0, imm21[1:0], 5'b0, imm21[20:2], rd});
      add_word = ADD_MATCH | {10'b0, aim[11:0], 10'b0};
      if (spoil) begin
         case ($urandom_range(0, 2))
            0: rn = rd ^ REG_W'($urandom_range(1, 31));
            1: add_word[22] = 1'b1;   // shifted imm12 is not the accepted form
            default: add_word[4:0] = rd ^ REG_W'($urandom_range(1, 31));
         endcase
      end
      if (!spoil || add_word[4:0] == 5'b0)
         add_word[4:0] = rd;
      add_word[9:5] = rn;
      put_word(add_word);
   endtask

   task automatic emit_function();
      int unsigned n;
      if ($urandom_range(0, 1))
         put_word(STP_FP_MATCH | WORD_W'($urandom_range(0, 127) << 15));
      else
         put_word(SUB_SP_MATCH | WORD_W'($urandom_range(0, 4095) << 10));
      n = $urandom_range(0, 6);
      repeat (n) begin
         case ($urandom_range(0, 9))
            3, 4: emit_pair(cfg_target, 1'b0);
            5:    emit_pair(cfg_target + 64'($urandom_range(1, 32'h3000)), 1'b0);
            6: begin
               // unpaired ADRP, then an ordinary word
               put_word(ADRP_MATCH | ($urandom & ~ADRP_MASK));
               put_word($urandom);
            end
            7:    emit_pair(cfg_target, 1'b1);
            8:    put_word(STP_FP_MATCH | WORD_W'($urandom_range(0, 127) << 15));
            default: put_word($urandom);
         endcase
      end
      if ($urandom_range(0, 99) < 85)
         put_word(RET_WORD);
   endtask

   task automatic emit_section();
      int unsigned n;
      logic [WORD_W-1:0] tail;
      n = $urandom_range(0, 2);
      repeat (n) begin
         if ($urandom_range(0, 1))
            put_word(ADRP_MATCH | ($urandom & ~ADRP_MASK));
         else
            put_word($urandom);
      end
      n = $urandom_range(0, 3);
      repeat (n) emit_function();
      case ($urandom_range(0, 3))
         0:       tail = RET_WORD;
         1:       tail = ADRP_MATCH | ($urandom & ~ADRP_MASK);
         2:       tail = SUB_SP_MATCH | ($urandom & ~SUB_SP_MASK);
         default: tail = $urandom;
      endcase
      put_word(tail, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // directed table: reset values first, then hand-built sections
   // ------------------------------------------------------------------------
   localparam int unsigned N_ROWS = 26;
   stim_row_type directed_rows [N_ROWS] = '{
      // reset configuration: base 0, target 0
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'(RET_WORD), 1'b0, ANS_NONE, '0},  // RET while scanning
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hA9BF7BFD,  1'b0, ANS_NONE, '0},  // STP prologue
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h90000000,  1'b0, ANS_NONE, '0},  // ADRP x0
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h91000000,  1'b0, ANS_NONE, '0},  // resolves 0: no match
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hFFFFFFFF,  1'b1, ANS_MISS, '0},
      // function at address zero forms 0x2345
      '{ROW_REG,  CSR_BASE_ADDRESS,   64'h0,    1'b0, ANS_NONE, '0},
      '{ROW_REG,  CSR_TARGET_ADDRESS, 64'h2345, 1'b0, ANS_NONE, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hD10083FF,  1'b0, ANS_NONE, '0},  // SUB sp prologue
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hD0000001,  1'b0, ANS_NONE, '0},  // ADRP x1, +2 pages
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h910D1421,  1'b0, ANS_NONE, '0},  // ADD x1, x1, #0x345
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'(RET_WORD), 1'b0, ANS_HIT,  '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hA9BF7BFD,  1'b0, ANS_NONE, '0},  // ignored once answered
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'(RET_WORD), 1'b1, ANS_NONE, '0},  // no miss once answered
      // address wrap and the all-ones target
      '{ROW_REG,  CSR_BASE_ADDRESS,   64'hFFFF_FFFF_FFFF_FFF8, 1'b0, ANS_NONE, '0},
      '{ROW_REG,  CSR_TARGET_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ANS_NONE, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hA9807BFD, 1'b0, ANS_NONE, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h9000001F, 1'b0, ANS_NONE, '0},  // ADRP x31
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h913FFFFF, 1'b0, ANS_NONE, '0},  // ADD x31, #0xFFF
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'(RET_WORD), 1'b1, ANS_HIT, 64'hFFFF_FFFF_FFFF_FFF8},
      // pairing corner cases
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h90000005, 1'b0, ANS_PREDICTED, '0},  // ADRP while scanning
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hD10003FF, 1'b0, ANS_PREDICTED, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h90000003, 1'b0, ANS_PREDICTED, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h91400063, 1'b0, ANS_PREDICTED, '0},  // shifted ADD
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'(RET_WORD), 1'b0, ANS_PREDICTED, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'hA9807BFD, 1'b0, ANS_PREDICTED, '0},
      '{ROW_BEAT, CSR_BASE_ADDRESS, 64'h90000009, 1'b1, ANS_MISS, '0}       // ADRP on last word
   };

   // ------------------------------------------------------------------------
   // result side: random stall, and the check against the oldest prediction
   // ------------------------------------------------------------------------
   initial begin
      int unsigned n;
      wait (!reset);
      forever begin
         rsp_stall <= 1'b0;
         repeat (1 + (calm_phase ? 0 : $urandom_range(0, 6))) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("tb: mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      finder_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat found=%0b addr=%h",
                                    rsp_found, rsp_function_address));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.found)
               flag_mismatch($sformatf("found: expected %0b, got %0b", want.found, rsp_found));
            if (rsp_function_address !== want.function_address)
               flag_mismatch($sformatf("function_address: expected %h, got %h",
                                       want.function_address, rsp_function_address));
         end
      end
   end

   // watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] target;
      logic [31:0]       reach;
      int unsigned       goal;

      // hold reset, then release it at an edge
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG)
            write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
         else
            put_word(directed_rows[i].value[WORD_W-1:0], directed_rows[i].last,
                     directed_rows[i].check, directed_rows[i].hit_addr);
      end

      // random sections over several settings; each phase drains first
      for (int ph = 0; ph < 6; ph++) begin
         reach = $urandom;
         base  = {$urandom, $urandom};
         case (ph)
            1:       base = '0;
            2:       base = 64'hFFFF_FFFF_FFFF_FF00;
            3:       base = 64'hFFFF_FFFF_FFFF_FFFF;
            default: ;
         endcase
         // keep the target within ADRP reach of the section
         target = base + {{32{reach[31]}}, reach};
         if (ph == 1)
            target = '0;
         else if (target == '0)
            target = 64'd1;
         write_reg(CSR_BASE_ADDRESS, base);
         write_reg(CSR_TARGET_ADDRESS, target);
         calm_phase = (ph == 4);
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) emit_section();
      end
      calm_phase = 1'b0;

      // drain everything, then give the pipeline time to show a stray beat
      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
